>>> rtl/vtpg_pkg.sv
// Shared types, request and command codes, register indexes and constants
// for the video test pattern generator. No dependencies.
`timescale 1ns / 1ps

package vtpg_pkg;

	localparam int COORD_W     = 12;
	localparam int IMG_MAX_W   = 256;
	localparam int IMG_MAX_H   = 256;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [11:0] FRAME_MAX_W = 12'd1920;
	localparam logic [11:0] FRAME_MAX_H = 12'd1200;

	// request codes on req_type
	localparam logic [2:0] REQ_PIXEL = 3'd0;
	localparam logic [2:0] REQ_TICK  = 3'd1;
	localparam logic [2:0] REQ_WRITE = 3'd2;
	localparam logic [2:0] REQ_MODE  = 3'd3;
	localparam logic [2:0] REQ_POLL  = 3'd4;

	// command codes carried through the queue
	typedef logic [2:0] cmd_kind_t;
	localparam cmd_kind_t CMD_NOP   = 3'd0;
	localparam cmd_kind_t CMD_GRAD  = 3'd1;
	localparam cmd_kind_t CMD_IMG   = 3'd2;
	localparam cmd_kind_t CMD_TICK  = 3'd3;
	localparam cmd_kind_t CMD_WRITE = 3'd4;
	localparam cmd_kind_t CMD_MODE  = 3'd5;
	localparam cmd_kind_t CMD_POLL  = 3'd6;

	// pattern modes
	localparam logic [1:0] MODE_ANIMATED = 2'd0;
	localparam logic [1:0] MODE_STATIC   = 2'd1;
	localparam logic [1:0] MODE_IMAGE    = 2'd2;

	// event codes
	localparam logic [1:0] EV_NONE    = 2'd0;
	localparam logic [1:0] EV_INVALID = 2'd1;
	localparam logic [1:0] EV_MODE    = 2'd2;
	localparam logic [1:0] EV_FRAME   = 2'd3;

	// pending flag bit positions
	localparam int FLAG_INVALID = 0;
	localparam int FLAG_MODE    = 1;
	localparam int FLAG_FRAME   = 2;

	// configuration register indexes
	localparam logic [2:0] CFG_PATTERN_MODE = 3'd0;
	localparam logic [2:0] CFG_BRIGHTNESS   = 3'd1;
	localparam logic [2:0] CFG_FRAME_WIDTH  = 3'd2;
	localparam logic [2:0] CFG_FRAME_HEIGHT = 3'd3;
	localparam logic [2:0] CFG_IMAGE_WIDTH  = 3'd4;
	localparam logic [2:0] CFG_IMAGE_HEIGHT = 3'd5;
	localparam logic [2:0] CFG_IMAGE_LOADED = 3'd6;

	// register reset values
	localparam logic [1:0]  RST_PATTERN_MODE = MODE_ANIMATED;
	localparam logic [5:0]  RST_BRIGHTNESS   = 6'd63;
	localparam logic [11:0] RST_FRAME_WIDTH  = 12'd640;
	localparam logic [11:0] RST_FRAME_HEIGHT = 12'd480;
	localparam logic [8:0]  RST_IMAGE_WIDTH  = 9'd256;
	localparam logic [8:0]  RST_IMAGE_HEIGHT = 9'd256;

	localparam logic [7:0] GRAD_CHAN0   = 8'd150;
	localparam logic [7:0] ALPHA_OPAQUE = 8'd255;
	localparam logic [5:0] SCALE_DIV    = 6'd63;

	// floor(p / 63) for p < 2**14: estimate with 1040 / 2**16, then one correction
	localparam logic [10:0] RECIP_63    = 11'd1040;
	localparam int          RECIP_SHIFT = 16;

	typedef struct packed {
		cmd_kind_t   kind;
		logic [7:0]  x_lo;
		logic [7:0]  y_lo;
		logic [23:0] texel;
	} cmd_t;

	typedef struct packed {
		logic [1:0]  pattern_mode;
		logic [5:0]  brightness;
		logic [11:0] frame_width;
		logic [11:0] frame_height;
	} cfg_t;

endpackage

>>> rtl/vtpg_queue.sv
// Short FIFO between the request front end and the execution back end.
// Depends on vtpg_pkg for the default depth.
`timescale 1ns / 1ps

module vtpg_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = vtpg_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             nempty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slots_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full   = (count_q == CNT_W'(DEPTH));
	assign nempty = (count_q != '0);
	assign rdata  = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10: count_q <= count_q + 1'b1;
				2'b01: count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

>>> rtl/vtpg_front.sv
// Front end: configuration registers, request intake and classification,
// bit-serial tiling remainder and image address. Depends on vtpg_pkg.
`timescale 1ns / 1ps

module vtpg_front #(
	parameter int IMG_MAX_W = vtpg_pkg::IMG_MAX_W,
	parameter int IMG_MAX_H = vtpg_pkg::IMG_MAX_H,
	parameter int ADDR_W    = $clog2(IMG_MAX_W * IMG_MAX_H)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [2:0]          cfg_index,
	input  logic [11:0]         cfg_data,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [2:0]          req_type,
	input  logic [11:0]         pos_x,
	input  logic [11:0]         pos_y,
	input  logic [23:0]         texel,
	output vtpg_pkg::cfg_t      cfg,
	output logic                push,
	output vtpg_pkg::cmd_t      push_cmd,
	output logic [ADDR_W-1:0]   push_addr,
	input  logic                q_full
);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_DIVIDE = 2'd1;
	localparam logic [1:0] ST_PUSH   = 2'd2;

	localparam int CW    = vtpg_pkg::COORD_W;
	localparam int CNT_W = $clog2(CW);

	logic [1:0]  pattern_mode_q;
	logic [5:0]  brightness_q;
	logic [11:0] frame_width_q;
	logic [11:0] frame_height_q;
	logic [8:0]  image_width_q;
	logic [8:0]  image_height_q;
	logic        image_loaded_q;

	logic [1:0]       state_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CW-1:0]    x_q;
	logic [CW-1:0]    y_q;
	logic [8:0]       rx_q;
	logic [8:0]       ry_q;

	logic [8:0]  w_eff;
	logic [8:0]  h_eff;
	logic        img_mode;
	logic        accept;
	logic        img_pixel;
	logic [9:0]  rx_sh;
	logic [9:0]  ry_sh;
	logic [9:0]  rx_n;
	logic [9:0]  ry_n;
	logic [CW-1:0]     row_sel;
	logic [CW-1:0]     col_sel;
	logic [ADDR_W-1:0] row_a;
	logic [ADDR_W-1:0] col_a;
	logic        write_in_range;
	vtpg_pkg::cmd_kind_t kind_d;

	assign cfg_ready = 1'b1;

	assign cfg.pattern_mode = pattern_mode_q;
	assign cfg.brightness   = brightness_q;
	assign cfg.frame_width  = frame_width_q;
	assign cfg.frame_height = frame_height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_mode_q <= vtpg_pkg::RST_PATTERN_MODE;
			brightness_q   <= vtpg_pkg::RST_BRIGHTNESS;
			frame_width_q  <= vtpg_pkg::RST_FRAME_WIDTH;
			frame_height_q <= vtpg_pkg::RST_FRAME_HEIGHT;
			image_width_q  <= vtpg_pkg::RST_IMAGE_WIDTH;
			image_height_q <= vtpg_pkg::RST_IMAGE_HEIGHT;
			image_loaded_q <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				vtpg_pkg::CFG_PATTERN_MODE: pattern_mode_q <= cfg_data[1:0];
				vtpg_pkg::CFG_BRIGHTNESS:   brightness_q   <= cfg_data[5:0];
				vtpg_pkg::CFG_FRAME_WIDTH:  frame_width_q  <= cfg_data;
				vtpg_pkg::CFG_FRAME_HEIGHT: frame_height_q <= cfg_data;
				vtpg_pkg::CFG_IMAGE_WIDTH:  image_width_q  <= cfg_data[8:0];
				vtpg_pkg::CFG_IMAGE_HEIGHT: image_height_q <= cfg_data[8:0];
				vtpg_pkg::CFG_IMAGE_LOADED: image_loaded_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// clamp tile size to 1 .. maximum
	always_comb begin
		if (image_width_q == '0) begin
			w_eff = 9'd1;
		end else if ({4'b0, image_width_q} > 13'(IMG_MAX_W)) begin
			w_eff = 9'(IMG_MAX_W);
		end else begin
			w_eff = image_width_q;
		end
		if (image_height_q == '0) begin
			h_eff = 9'd1;
		end else if ({4'b0, image_height_q} > 13'(IMG_MAX_H)) begin
			h_eff = 9'(IMG_MAX_H);
		end else begin
			h_eff = image_height_q;
		end
	end

	assign img_mode  = (pattern_mode_q == vtpg_pkg::MODE_IMAGE) && image_loaded_q;
	assign in_ready  = (state_q == ST_IDLE) && !q_full;
	assign accept    = in_valid && in_ready;
	assign img_pixel = (req_type == vtpg_pkg::REQ_PIXEL) && img_mode;

	assign write_in_range = ({1'b0, pos_x} < 13'(IMG_MAX_W)) &&
		({1'b0, pos_y} < 13'(IMG_MAX_H));

	always_comb begin
		case (req_type)
			vtpg_pkg::REQ_PIXEL: kind_d = vtpg_pkg::CMD_GRAD;
			vtpg_pkg::REQ_TICK:  kind_d = vtpg_pkg::CMD_TICK;
			vtpg_pkg::REQ_WRITE: kind_d = write_in_range ? vtpg_pkg::CMD_WRITE : vtpg_pkg::CMD_NOP;
			vtpg_pkg::REQ_MODE:  kind_d = vtpg_pkg::CMD_MODE;
			vtpg_pkg::REQ_POLL:  kind_d = vtpg_pkg::CMD_POLL;
			default:             kind_d = vtpg_pkg::CMD_NOP;
		endcase
	end

	// one remainder bit per cycle, most significant first
	assign rx_sh = {rx_q, x_q[cnt_q]};
	assign ry_sh = {ry_q, y_q[cnt_q]};
	assign rx_n  = (rx_sh >= {1'b0, w_eff}) ? rx_sh - {1'b0, w_eff} : rx_sh;
	assign ry_n  = (ry_sh >= {1'b0, h_eff}) ? ry_sh - {1'b0, h_eff} : ry_sh;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			rx_q    <= '0;
			ry_q    <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept && img_pixel) begin
						state_q <= ST_DIVIDE;
						cnt_q   <= CNT_W'(CW - 1);
						rx_q    <= '0;
						ry_q    <= '0;
					end
				end
				ST_DIVIDE: begin
					rx_q <= rx_n[8:0];
					ry_q <= ry_n[8:0];
					if (cnt_q == '0) begin
						state_q <= ST_PUSH;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				ST_PUSH: begin
					if (!q_full) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x_q <= pos_x;
			y_q <= pos_y;
		end
	end

	assign push = (accept && !img_pixel) || ((state_q == ST_PUSH) && !q_full);

	assign row_sel = (state_q == ST_PUSH) ? CW'(ry_q) : pos_y;
	assign col_sel = (state_q == ST_PUSH) ? CW'(rx_q) : pos_x;
	assign row_a   = ADDR_W'(row_sel);
	assign col_a   = ADDR_W'(col_sel);
	assign push_addr = row_a * ADDR_W'(IMG_MAX_W) + col_a;

	always_comb begin
		push_cmd.kind  = (state_q == ST_PUSH) ? vtpg_pkg::CMD_IMG : kind_d;
		push_cmd.x_lo  = pos_x[7:0];
		push_cmd.y_lo  = pos_y[7:0];
		push_cmd.texel = texel;
	end

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_full)
		else $error("front pushed into a full queue");

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_PUSH |-> (rx_q < w_eff) && (ry_q < h_eff))
		else $error("tiling remainder not below tile size");

endmodule

>>> rtl/vtpg_back.sv
// Back end: frame and event state, image memory, gradient generation and the
// brightness scaling pipeline with the result register. Depends on vtpg_pkg.
`timescale 1ns / 1ps

module vtpg_back #(
	parameter int IMG_MAX_W = vtpg_pkg::IMG_MAX_W,
	parameter int IMG_MAX_H = vtpg_pkg::IMG_MAX_H,
	parameter int ADDR_W    = $clog2(IMG_MAX_W * IMG_MAX_H)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  vtpg_pkg::cfg_t    cfg,
	input  logic              q_nempty,
	input  vtpg_pkg::cmd_t    cmd,
	input  logic [ADDR_W-1:0] cmd_addr,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [7:0]        chan0,
	output logic [7:0]        chan1,
	output logic [7:0]        chan2,
	output logic [7:0]        alpha,
	output logic [1:0]        event_code
);

	localparam int MEM_DEPTH = IMG_MAX_W * IMG_MAX_H;

	logic [23:0] mem [MEM_DEPTH];

	logic [7:0] tick_q;
	logic [2:0] flags_q;
	logic [7:0] tick_d;
	logic [2:0] flags_d;
	logic [1:0] ev_d;
	logic       en;

	logic                v_s1, v_s2, v_s3, v_s4;
	vtpg_pkg::cmd_kind_t kind_s1;
	logic [2:0][7:0]     grad_s1;
	logic [23:0]         rd_s1;
	logic [1:0]          ev_s1;
	logic [2:0][13:0]    p_s2;
	logic                pix_s2;
	logic [1:0]          ev_s2;
	logic [2:0][13:0]    p_s3;
	logic [2:0][7:0]     q_s3;
	logic                pix_s3;
	logic [1:0]          ev_s3;
	logic [2:0][7:0]     chan_s4;
	logic                pix_s4;
	logic [1:0]          ev_s4;

	logic [2:0][7:0]  raw;
	logic [2:0][7:0]  grad_d;
	logic [2:0][24:0] recip_m;
	logic [2:0][13:0] rem;

	assign en  = !v_s4 || out_ready;
	assign pop = en && q_nempty;

	always_comb begin
		tick_d  = tick_q;
		flags_d = flags_q;
		ev_d    = vtpg_pkg::EV_NONE;
		if (pop) begin
			case (cmd.kind)
				vtpg_pkg::CMD_TICK: begin
					if ((cfg.frame_width > vtpg_pkg::FRAME_MAX_W) ||
						(cfg.frame_height > vtpg_pkg::FRAME_MAX_H)) begin
						flags_d[vtpg_pkg::FLAG_INVALID] = 1'b1;
					end else begin
						flags_d[vtpg_pkg::FLAG_FRAME] = 1'b1;
						if (cfg.pattern_mode == vtpg_pkg::MODE_ANIMATED) begin
							tick_d = tick_q + 1'b1;
						end
					end
				end
				vtpg_pkg::CMD_MODE: begin
					flags_d[vtpg_pkg::FLAG_MODE] = 1'b1;
				end
				vtpg_pkg::CMD_POLL: begin
					if (flags_q[vtpg_pkg::FLAG_INVALID]) begin
						flags_d[vtpg_pkg::FLAG_INVALID] = 1'b0;
						ev_d = vtpg_pkg::EV_INVALID;
					end else if (flags_q[vtpg_pkg::FLAG_MODE]) begin
						flags_d[vtpg_pkg::FLAG_MODE] = 1'b0;
						ev_d = vtpg_pkg::EV_MODE;
					end else if (flags_q[vtpg_pkg::FLAG_FRAME]) begin
						flags_d[vtpg_pkg::FLAG_FRAME] = 1'b0;
						ev_d = vtpg_pkg::EV_FRAME;
					end
				end
				default: ;
			endcase
		end
	end

	assign grad_d[0] = vtpg_pkg::GRAD_CHAN0;
	assign grad_d[1] = tick_q + cmd.y_lo;
	assign grad_d[2] = tick_q + cmd.x_lo;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q  <= '0;
			flags_q <= '0;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			v_s4    <= 1'b0;
		end else begin
			tick_q  <= tick_d;
			flags_q <= flags_d;
			if (en) begin
				v_s1 <= pop;
				v_s2 <= v_s1;
				v_s3 <= v_s2;
				v_s4 <= v_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (cmd.kind == vtpg_pkg::CMD_WRITE) begin
				mem[cmd_addr] <= cmd.texel;
			end
			rd_s1 <= mem[cmd_addr];
		end
	end

	// select raw channels, then scale by brightness / 63 over three stages
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			case (kind_s1)
				vtpg_pkg::CMD_IMG:  raw[k] = rd_s1[8*k +: 8];
				vtpg_pkg::CMD_GRAD: raw[k] = grad_s1[k];
				default:            raw[k] = 8'd0;
			endcase
			recip_m[k] = 25'(p_s2[k]) * 25'(vtpg_pkg::RECIP_63);
			rem[k]     = p_s3[k] - ({q_s3[k], 6'b0} - 14'(q_s3[k]));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kind_s1 <= cmd.kind;
			grad_s1 <= grad_d;
			ev_s1   <= ev_d;

			for (int k = 0; k < 3; k++) begin
				p_s2[k] <= 14'(raw[k]) * 14'(cfg.brightness);
			end
			pix_s2 <= (kind_s1 == vtpg_pkg::CMD_IMG) || (kind_s1 == vtpg_pkg::CMD_GRAD);
			ev_s2  <= ev_s1;

			for (int k = 0; k < 3; k++) begin
				q_s3[k] <= recip_m[k][vtpg_pkg::RECIP_SHIFT +: 8];
			end
			p_s3   <= p_s2;
			pix_s3 <= pix_s2;
			ev_s3  <= ev_s2;

			for (int k = 0; k < 3; k++) begin
				chan_s4[k] <= (rem[k] >= 14'(vtpg_pkg::SCALE_DIV)) ? q_s3[k] + 1'b1 : q_s3[k];
			end
			pix_s4 <= pix_s3;
			ev_s4  <= ev_s3;
		end
	end

	assign out_valid  = v_s4;
	assign chan0      = chan_s4[0];
	assign chan1      = chan_s4[1];
	assign chan2      = chan_s4[2];
	assign alpha      = pix_s4 ? vtpg_pkg::ALPHA_OPAQUE : 8'd0;
	assign event_code = ev_s4;

	a_ev_poll_only: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && (kind_s1 != vtpg_pkg::CMD_POLL) |-> ev_s1 == vtpg_pkg::EV_NONE)
		else $error("event code on a request that is not a poll");

	a_poll_clears: assert property (@(posedge clk) disable iff (!arst_n)
		pop && (cmd.kind == vtpg_pkg::CMD_POLL) && flags_q[vtpg_pkg::FLAG_INVALID]
		|=> !flags_q[vtpg_pkg::FLAG_INVALID])
		else $error("poll left the invalid flag pending");

	a_tick_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && (cmd.kind == vtpg_pkg::CMD_TICK)) |=> $stable(tick_q))
		else $error("tick counter moved without a frame tick");

endmodule

>>> rtl/video_test_pattern_generator_core.sv
// Top level of the video test pattern generator: front end, command queue
// and back end. Depends on vtpg_pkg, vtpg_front, vtpg_queue and vtpg_back.
//
// Each request (pixel, frame tick, texel write, mode notice, event poll)
// returns exactly one result, in request order. The front end takes one
// request per cycle into a two-entry queue while it is not full, except a
// pixel in image mode with an image loaded: that one holds the input while
// a bit-serial remainder unit works out the tiled column and row, one bit
// of the 12-bit coordinates per cycle. The back end executes one queued
// command per cycle while out_ready does not hold it, through image memory
// read, multiply by brightness, reciprocal estimate and correction into the
// result register, so gradient pixels and control requests sustain one per
// cycle without stalls. The image memory holds IMG_MAX_W * IMG_MAX_H
// texels and has no reset: read only texels that have been written.
// Configuration writes are taken at any time and must be made while idle.
`timescale 1ns / 1ps

module video_test_pattern_generator_core #(
	parameter int IMG_MAX_W = vtpg_pkg::IMG_MAX_W,
	parameter int IMG_MAX_H = vtpg_pkg::IMG_MAX_H
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [11:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  req_type,
	input  logic [11:0] pos_x,
	input  logic [11:0] pos_y,
	input  logic [23:0] texel,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  chan0,
	output logic [7:0]  chan1,
	output logic [7:0]  chan2,
	output logic [7:0]  alpha,
	output logic [1:0]  event_code
);

	localparam int ADDR_W = $clog2(IMG_MAX_W * IMG_MAX_H);
	localparam int Q_W    = $bits(vtpg_pkg::cmd_t) + ADDR_W;

	vtpg_pkg::cfg_t    cfg;
	logic              push;
	vtpg_pkg::cmd_t    push_cmd;
	logic [ADDR_W-1:0] push_addr;
	logic              q_full;
	logic              q_nempty;
	logic              pop;
	logic [Q_W-1:0]    q_wdata;
	logic [Q_W-1:0]    q_rdata;
	vtpg_pkg::cmd_t    pop_cmd;
	logic [ADDR_W-1:0] pop_addr;

	vtpg_front #(
		.IMG_MAX_W (IMG_MAX_W),
		.IMG_MAX_H (IMG_MAX_H),
		.ADDR_W    (ADDR_W)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.req_type  (req_type),
		.pos_x     (pos_x),
		.pos_y     (pos_y),
		.texel     (texel),
		.cfg       (cfg),
		.push      (push),
		.push_cmd  (push_cmd),
		.push_addr (push_addr),
		.q_full    (q_full)
	);

	assign q_wdata  = {push_cmd, push_addr};
	assign pop_cmd  = vtpg_pkg::cmd_t'(q_rdata[Q_W-1:ADDR_W]);
	assign pop_addr = q_rdata[ADDR_W-1:0];

	vtpg_queue #(
		.WIDTH (Q_W),
		.DEPTH (vtpg_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (q_wdata),
		.full   (q_full),
		.pop    (pop),
		.rdata  (q_rdata),
		.nempty (q_nempty)
	);

	vtpg_back #(
		.IMG_MAX_W (IMG_MAX_W),
		.IMG_MAX_H (IMG_MAX_H),
		.ADDR_W    (ADDR_W)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.q_nempty   (q_nempty),
		.cmd        (pop_cmd),
		.cmd_addr   (pop_addr),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.chan0      (chan0),
		.chan1      (chan1),
		.chan2      (chan2),
		.alpha      (alpha),
		.event_code (event_code)
	);

endmodule
